@@ rtl/e2c_pkg.sv @@
`default_nettype none

package e2c_pkg;

	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned ZONE_W  = 16;
	localparam int unsigned SUM_W   = 33;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned SOD_W   = 17;

	localparam logic [SOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0]       SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]        SECS_PER_MIN  = 6'd60;
	localparam logic [10:0]       DAYS_PER_QUAD = 11'd1461;
	localparam logic [11:0]       BASE_YEAR     = 12'd1970;
	// day count of 2100-03-01; 2100 is not a leap year, so one day is skipped there
	localparam logic [DAYS_W-1:0] DAYS_TO_MAR_2100 = 16'd47541;

	localparam logic [10:0] YEAR1_START = 11'd365;
	localparam logic [10:0] YEAR2_START = 11'd730;
	localparam logic [10:0] YEAR3_START = 11'd1096;

	// ceil(2^k / d) reciprocals, exact for the input widths used
	localparam longint unsigned RECIP_DAY_L  = ((64'd1 << 36) + 64'd674) / 64'd675;
	localparam longint unsigned RECIP_QUAD_L = ((64'd1 << 27) + 64'd1460) / 64'd1461;
	localparam longint unsigned RECIP_HOUR_L = ((64'd1 << 21) + 64'd224) / 64'd225;
	localparam longint unsigned RECIP_MIN_L  = ((64'd1 << 14) + 64'd14) / 64'd15;

	localparam logic [26:0] RECIP_DAY  = 27'(RECIP_DAY_L);
	localparam logic [16:0] RECIP_QUAD = 17'(RECIP_QUAD_L);
	localparam logic [13:0] RECIP_HOUR = 14'(RECIP_HOUR_L);
	localparam logic [10:0] RECIP_MIN  = 11'(RECIP_MIN_L);

	// day of year on which month idx (0 = January) begins
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		base = 9'd0;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && idx >= 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

`default_nettype wire

@@ rtl/e2c_date.sv @@
`default_nettype none

module e2c_date
	import e2c_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [DAYS_W-1:0] days,
	output logic      [11:0]       year,
	output logic      [3:0]        month,
	output logic      [4:0]        day_of_month
);

	logic [DAYS_W-1:0] adj_s3;
	logic [DAYS_W-1:0] adj_s4;
	logic [5:0]        quad_s4;
	logic [5:0]        quad_s5;
	logic [10:0]       rem_s5;
	logic [11:0]       year_s6;
	logic [8:0]        doy_s6;
	logic              leap_s6;
	logic [11:0]       year_s7;
	logic [3:0]        month_s7;
	logic [4:0]        day_s7;

	logic [32:0] quad_prod;
	logic [10:0] quad_days;
	logic [1:0]  yo;
	logic [10:0] yo_start;
	logic [3:0]  mi;
	logic [8:0]  mstart;

	// insert a phantom Feb 29 2100 so the plain 4-year rule holds
	always_ff @(posedge clk) begin
		adj_s3 <= (days >= DAYS_TO_MAR_2100) ? days + 16'd1 : days;
	end

	assign quad_prod = 33'(adj_s3) * 33'(RECIP_QUAD);

	always_ff @(posedge clk) begin
		adj_s4  <= adj_s3;
		quad_s4 <= quad_prod[32:27];
	end

	assign quad_days = 11'(17'(quad_s4) * 17'(DAYS_PER_QUAD));

	always_ff @(posedge clk) begin
		quad_s5 <= quad_s4;
		rem_s5  <= adj_s4[10:0] - quad_days;
	end

	always_comb begin
		if (rem_s5 >= YEAR3_START) begin
			yo = 2'd3;
			yo_start = YEAR3_START;
		end else if (rem_s5 >= YEAR2_START) begin
			yo = 2'd2;
			yo_start = YEAR2_START;
		end else if (rem_s5 >= YEAR1_START) begin
			yo = 2'd1;
			yo_start = YEAR1_START;
		end else begin
			yo = 2'd0;
			yo_start = 11'd0;
		end
	end

	always_ff @(posedge clk) begin
		year_s6 <= BASE_YEAR + {4'd0, quad_s5, 2'd0} + {10'd0, yo};
		doy_s6  <= 9'(rem_s5 - yo_start);
		leap_s6 <= (yo == 2'd2);
	end

	always_comb begin
		mi = 4'd0;
		for (int i = 0; i < 12; i++) begin
			if (doy_s6 >= month_start(leap_s6, 4'(i))) begin
				mi = 4'(i);
			end
		end
		mstart = month_start(leap_s6, mi);
	end

	always_ff @(posedge clk) begin
		year_s7  <= year_s6;
		month_s7 <= mi + 4'd1;
		day_s7   <= 5'(doy_s6 - mstart) + 5'd1;
	end

	assign year         = year_s7;
	assign month        = month_s7;
	assign day_of_month = day_s7;

endmodule

`default_nettype wire

@@ rtl/e2c_tod.sv @@
`default_nettype none

module e2c_tod
	import e2c_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [SOD_W-1:0]  t_low,
	input  wire logic [DAYS_W-1:0] days,
	output logic      [4:0]        hour,
	output logic      [5:0]        minute,
	output logic      [5:0]        second
);

	logic [SOD_W-1:0] sod_s3;
	logic [SOD_W-1:0] sod_s4;
	logic [4:0]       hour_s4;
	logic [4:0]       hour_s5;
	logic [11:0]      remh_s5;
	logic [4:0]       hour_s6;
	logic [11:0]      remh_s6;
	logic [5:0]       min_s6;
	logic [4:0]       hour_s7;
	logic [5:0]       min_s7;
	logic [5:0]       sec_s7;

	logic [32:0] day_prod;
	logic [25:0] hour_prod;
	logic [11:0] hour_secs;
	logic [19:0] min_prod;
	logic [5:0]  min_secs;

	// sod < 86400, so the low bits of the difference are exact
	assign day_prod = 33'(days) * 33'(SECS_PER_DAY);

	always_ff @(posedge clk) begin
		sod_s3 <= t_low - day_prod[SOD_W-1:0];
	end

	assign hour_prod = 26'(sod_s3[SOD_W-1:4]) * 26'(RECIP_HOUR);

	always_ff @(posedge clk) begin
		sod_s4  <= sod_s3;
		hour_s4 <= hour_prod[25:21];
	end

	assign hour_secs = 12'(17'(hour_s4) * 17'(SECS_PER_HOUR));

	always_ff @(posedge clk) begin
		hour_s5 <= hour_s4;
		remh_s5 <= sod_s4[11:0] - hour_secs;
	end

	assign min_prod = 20'(remh_s5[11:2]) * 20'(RECIP_MIN);

	always_ff @(posedge clk) begin
		hour_s6 <= hour_s5;
		remh_s6 <= remh_s5;
		min_s6  <= min_prod[19:14];
	end

	assign min_secs = 6'(12'(min_s6) * 12'(SECS_PER_MIN));

	always_ff @(posedge clk) begin
		hour_s7 <= hour_s6;
		min_s7  <= min_s6;
		sec_s7  <= remh_s6[5:0] - min_secs;
	end

	assign hour   = hour_s7;
	assign minute = min_s7;
	assign second = sec_s7;

endmodule

`default_nettype wire

@@ rtl/epoch_to_calendar_date_time.sv @@
`default_nettype none

// Converts a 32-bit Unix time plus the zone offset (added exactly, no wrap) into
// Gregorian year, month, day of month, hour, minute and second. A seven-stage
// pipeline of constant-reciprocal multiplies: one beat may start every cycle,
// busy never rises, and each result shows on the ports for one cycle with done
// high, once its beat has left the last stage. The receiver cannot
// stall. The user must write zone_offset_seconds through cfg_we/cfg_wdata only
// while no beat is in flight; the block itself does not enforce this.

module epoch_to_calendar_date_time
	import e2c_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [ZONE_W-1:0]  cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [EPOCH_W-1:0] epoch_seconds,
	output logic                    done,
	output logic      [11:0]        year,
	output logic      [3:0]         month,
	output logic      [4:0]         day_of_month,
	output logic      [4:0]         hour,
	output logic      [5:0]         minute,
	output logic      [5:0]         second
);

	logic [ZONE_W-1:0] zone_offset_q;
	logic [6:0]        vld_q;
	logic [SUM_W-1:0]  t_s1;
	logic [SUM_W-1:0]  t_s2;
	logic [DAYS_W-1:0] days_s2;
	logic [51:0]       days_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset_q <= '0;
			vld_q         <= '0;
		end else begin
			if (cfg_we) begin
				zone_offset_q <= cfg_wdata;
			end
			vld_q <= {vld_q[5:0], start};
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= SUM_W'(epoch_seconds) + SUM_W'(zone_offset_q);
	end

	// days = t / 86400 = (t >> 7) / 675
	assign days_prod = 52'(t_s1[SUM_W-1:7]) * 52'(RECIP_DAY);

	always_ff @(posedge clk) begin
		t_s2    <= t_s1;
		days_s2 <= days_prod[51:36];
	end

	e2c_date u_date (
		.clk          (clk),
		.days         (days_s2),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	e2c_tod u_tod (
		.clk    (clk),
		.t_low  (t_s2[SOD_W-1:0]),
		.days   (days_s2),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	assign busy = 1'b0;
	assign done = vld_q[6];

endmodule

`default_nettype wire
